>>> src/isp_pkg.sv
// ============================================================================
// isp_pkg
// Shared types, codes, phase target tables and duration lookup for the
// intersection phase sequencer.
// ============================================================================
package isp_pkg;

  localparam int unsigned MaxLights = 16;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned ElapsedW  = 13;
  localparam int unsigned DurW      = 12;
  localparam int unsigned TimerW    = 9;
  localparam int unsigned YellowW   = 8;

  localparam logic [PhaseW-1:0] PhMainLeft     = 3'd0;
  localparam logic [PhaseW-1:0] PhMainStraight = 3'd1;
  localparam logic [PhaseW-1:0] PhLast         = 3'd6;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_JUMP    = 2'd1,
    OP_REQUEST = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    COL_RED    = 2'd0,
    COL_GREEN  = 2'd1,
    COL_YELLOW = 2'd2
  } color_e;

  typedef enum logic [2:0] {
    REG_YELLOW_TICKS  = 3'd0,
    REG_DUR_MAIN_LEFT = 3'd1,
    REG_DUR_MAIN_STR  = 3'd2,
    REG_DUR_MAIN_PED  = 3'd3,
    REG_DUR_SUB_LEFT  = 3'd4,
    REG_DUR_SUB_PED   = 3'd5,
    REG_DUR_ALL_PED   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [YellowW-1:0] yellow_ticks;
    logic [DurW-1:0]    dur_main_left;
    logic [DurW-1:0]    dur_main_straight;
    logic [DurW-1:0]    dur_main_ped;
    logic [DurW-1:0]    dur_sub_left;
    logic [DurW-1:0]    dur_sub_ped;
    logic [DurW-1:0]    dur_all_ped;
  } cfg_t;

  // Per-step commands broadcast from the phase controller to every light.
  typedef struct packed {
    logic                 tick;
    logic                 aim;
    logic [MaxLights-1:0] target;
  } light_ctrl_t;

  // Phase-side fields of the result, as they stand after the step.
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              changed;
    logic [PhaseW-1:0] pending;
  } phase_res_t;

  function automatic logic [MaxLights-1:0] phase_targets(input logic [PhaseW-1:0] p);
    logic [MaxLights-1:0] t;
    unique case (p)
      3'd0:    t = 16'hA8A8;
      3'd1:    t = 16'hC8C8;
      3'd2:    t = 16'h40A1;
      3'd3:    t = 16'h8A8A;
      3'd4:    t = 16'h8C8C;
      3'd5:    t = 16'h1414;
      3'd6:    t = 16'h1111;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Phase four is a transit phase with no duration of its own.
  function automatic logic [DurW-1:0] phase_duration(input logic [PhaseW-1:0] p,
                                                     input cfg_t cfg);
    logic [DurW-1:0] d;
    unique case (p)
      3'd0:    d = cfg.dur_main_left;
      3'd1:    d = cfg.dur_main_straight;
      3'd2:    d = cfg.dur_main_ped;
      3'd3:    d = cfg.dur_sub_left;
      3'd5:    d = cfg.dur_sub_ped;
      3'd6:    d = cfg.dur_all_ped;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

>>> src/isp_phase_ctrl.sv
// ============================================================================
// isp_phase_ctrl
// Phase state: current phase, pending request, phase timer and length.
// Decides expiry and the next phase, and drives the light commands.
// ============================================================================
module isp_phase_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  isp_pkg::opcode_e          opcode_i,
  input  logic [isp_pkg::PhaseW-1:0] phase_arg_i,
  input  isp_pkg::cfg_t             cfg_i,
  output isp_pkg::light_ctrl_t      ctrl_o,
  output isp_pkg::phase_res_t       res_o
);
  import isp_pkg::*;

  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [PhaseW-1:0]   pending_q, pending_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [DurW-1:0]     length_q, length_d;

  logic                is_tick, jump_ok, expire, taken;
  logic [PhaseW-1:0]   phase_j;
  logic [ElapsedW-1:0] elapsed_j;
  logic [DurW-1:0]     length_j;

  always_comb begin
    is_tick  = (opcode_i == OP_TICK) || (opcode_i == OP_JUMP);
    jump_ok  = (opcode_i == OP_JUMP) && (phase_arg_i <= PhLast);
    phase_j   = jump_ok ? phase_arg_i : phase_q;
    elapsed_j = jump_ok ? '0 : elapsed_q;
    length_j  = jump_ok ? phase_duration(phase_arg_i, cfg_i) : length_q;
    expire    = is_tick && (elapsed_j >= {1'b0, length_j});

    phase_d   = phase_j;
    pending_d = pending_q;
    elapsed_d = elapsed_j;
    length_d  = length_j;
    taken     = 1'b0;

    if (opcode_i == OP_REQUEST) begin
      pending_d = phase_arg_i;
    end

    if (expire) begin
      elapsed_d = '0;
      priority if (pending_q <= PhMainStraight) begin
        phase_d = (phase_j == PhMainStraight) ? PhMainLeft : PhMainStraight;
      end else if (pending_q <= PhLast) begin
        phase_d   = pending_q;
        pending_d = '0;
        taken     = 1'b1;
      end else begin
        // A request beyond the last phase keeps the phase and stays pending.
        phase_d = phase_j;
      end
      length_d = phase_duration(phase_d, cfg_i);
    end

    if (is_tick && (elapsed_d != {ElapsedW{1'b1}})) begin
      elapsed_d = elapsed_d + ElapsedW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhMainLeft;
      pending_q <= '0;
      elapsed_q <= '0;
      length_q  <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      elapsed_q <= elapsed_d;
      length_q  <= length_d;
    end
  end

  assign ctrl_o.tick   = is_tick;
  assign ctrl_o.aim    = expire;
  assign ctrl_o.target = phase_targets(phase_d);

  assign res_o.phase   = phase_d;
  assign res_o.changed = taken;
  assign res_o.pending = pending_d;

endmodule

>>> src/isp_light.sv
// ============================================================================
// isp_light
// One light lane: on/off state, color, transition flag and transition timer.
// ============================================================================
module isp_light #(
  parameter logic RST_CHANGING = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         tick_i,
  input  logic                         aim_i,
  input  logic                         target_i,
  input  logic [isp_pkg::YellowW-1:0]  yellow_ticks_i,
  output isp_pkg::color_e              color_o
);
  import isp_pkg::*;

  color_e            color_q, color_d;
  logic              on_q, on_d;
  logic              changing_q, changing_d;
  logic [TimerW-1:0] timer_q, timer_d;

  logic [TimerW-1:0] timer_inc;
  logic [TimerW:0]   green_at;

  assign green_at  = {2'b00, yellow_ticks_i} + (TimerW+1)'(2);
  assign timer_inc = (timer_q == {TimerW{1'b1}}) ? timer_q : timer_q + TimerW'(1);

  always_comb begin
    color_d    = color_q;
    on_d       = on_q;
    changing_d = changing_q;
    timer_d    = timer_q;

    // A light already moving toward the target state ignores the re-aim.
    if (aim_i && (on_q != target_i)) begin
      changing_d = 1'b1;
      if (on_q) begin
        color_d = COL_YELLOW;
      end
    end

    if (tick_i && changing_d) begin
      timer_d = timer_inc;
      priority if ((timer_inc >= {1'b0, yellow_ticks_i}) && (color_d == COL_YELLOW)) begin
        on_d       = 1'b0;
        color_d    = COL_RED;
        timer_d    = '0;
        changing_d = 1'b0;
      end else if ({1'b0, timer_inc} >= green_at) begin
        on_d       = 1'b1;
        color_d    = COL_GREEN;
        timer_d    = '0;
        changing_d = 1'b0;
      end else begin
        timer_d = timer_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q    <= COL_RED;
      on_q       <= 1'b0;
      changing_q <= RST_CHANGING;
      timer_q    <= '0;
    end else if (accept_i) begin
      color_q    <= color_d;
      on_q       <= on_d;
      changing_q <= changing_d;
      timer_q    <= timer_d;
    end
  end

  assign color_o = color_d;

endmodule

>>> src/intersection_phase_sequencer.sv
// ============================================================================
// intersection_phase_sequencer
// Seven-phase intersection sequencer driving up to sixteen lights, with an
// APB register port for the yellow time and the phase durations.
// ============================================================================
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while m_axis_tready_i is high; the only storage
// between items is the phase state, the light lanes and a single result register.
// Reset (rst_ni low, asynchronous): phase 0, no request, all lights red,
// phase-0 lights already moving toward green, registers at their defaults.
// ============================================================================
module intersection_phase_sequencer #(
  parameter int unsigned NUM_LIGHTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input items.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [2:0] phase_arg, [7:3] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode

  // Result items.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [2:0] phase, [3] phase_changed,
                                        // [6:4] pending_phase, [22:7] red_mask,
                                        // [38:23] green_mask, [54:39] yellow_mask,
                                        // [55] zero

  // Register port.
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import isp_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Register i lives at byte address 4*i; addresses
  // past the last register read as zero and ignore writes.
  // --------------------------------------------------------------------------
  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_write;

  assign pready_o  = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr_i[4:2]);
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.yellow_ticks      <= 8'd3;
      cfg_q.dur_main_left     <= 12'd20;
      cfg_q.dur_main_straight <= 12'd30;
      cfg_q.dur_main_ped      <= 12'd15;
      cfg_q.dur_sub_left      <= 12'd15;
      cfg_q.dur_sub_ped       <= 12'd15;
      cfg_q.dur_all_ped       <= 12'd20;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_YELLOW_TICKS:  cfg_q.yellow_ticks      <= pwdata_i[YellowW-1:0];
        REG_DUR_MAIN_LEFT: cfg_q.dur_main_left     <= pwdata_i[DurW-1:0];
        REG_DUR_MAIN_STR:  cfg_q.dur_main_straight <= pwdata_i[DurW-1:0];
        REG_DUR_MAIN_PED:  cfg_q.dur_main_ped      <= pwdata_i[DurW-1:0];
        REG_DUR_SUB_LEFT:  cfg_q.dur_sub_left      <= pwdata_i[DurW-1:0];
        REG_DUR_SUB_PED:   cfg_q.dur_sub_ped       <= pwdata_i[DurW-1:0];
        REG_DUR_ALL_PED:   cfg_q.dur_all_ped       <= pwdata_i[DurW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_YELLOW_TICKS:  prdata_o = 32'(cfg_q.yellow_ticks);
      REG_DUR_MAIN_LEFT: prdata_o = 32'(cfg_q.dur_main_left);
      REG_DUR_MAIN_STR:  prdata_o = 32'(cfg_q.dur_main_straight);
      REG_DUR_MAIN_PED:  prdata_o = 32'(cfg_q.dur_main_ped);
      REG_DUR_SUB_LEFT:  prdata_o = 32'(cfg_q.dur_sub_left);
      REG_DUR_SUB_PED:   prdata_o = 32'(cfg_q.dur_sub_ped);
      REG_DUR_ALL_PED:   prdata_o = 32'(cfg_q.dur_all_ped);
      default:           prdata_o = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake. The result register decouples the two sides: a new item is
  // taken whenever the register is empty or is being emptied this cycle.
  // --------------------------------------------------------------------------
  logic accept;
  logic out_valid_q, out_valid_d;
  logic [55:0] out_data_q, out_data_d;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // --------------------------------------------------------------------------
  // Phase controller and the light lanes. Both update their state on every
  // accepted item and expose the post-step values for the result.
  // --------------------------------------------------------------------------
  light_ctrl_t ctrl;
  phase_res_t  pres;

  isp_phase_ctrl u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (opcode_e'(s_axis_tuser_i)),
    .phase_arg_i (s_axis_tdata_i[PhaseW-1:0]),
    .cfg_i       (cfg_q),
    .ctrl_o      (ctrl),
    .res_o       (pres)
  );

  logic [MaxLights-1:0] red_d, green_d, yellow_d;
  localparam logic [MaxLights-1:0] RstTargets = 16'hA8A8;

  for (genvar i = 0; i < MaxLights; i++) begin : g_light
    if (i < NUM_LIGHTS) begin : g_used
      color_e color;

      isp_light #(
        .RST_CHANGING (RstTargets[i])
      ) u_light (
        .clk_i          (clk_i),
        .rst_ni         (rst_ni),
        .accept_i       (accept),
        .tick_i         (ctrl.tick),
        .aim_i          (ctrl.aim),
        .target_i       (ctrl.target[i]),
        .yellow_ticks_i (cfg_q.yellow_ticks),
        .color_o        (color)
      );

      assign red_d[i]    = (color == COL_RED);
      assign green_d[i]  = (color == COL_GREEN);
      assign yellow_d[i] = (color == COL_YELLOW);
    end else begin : g_unused
      assign red_d[i]    = 1'b0;
      assign green_d[i]  = 1'b0;
      assign yellow_d[i] = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  assign out_data_d = {1'b0, yellow_d, green_d, red_d, pres.pending, pres.changed, pres.phase};

  always_comb begin
    priority if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // Every accepted item produces a result in the next cycle.
  a_accept_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item did not produce a result");

  // A light never shows two colors at once.
  a_colors_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (((out_data_q[22:7] & out_data_q[38:23]) == '0) &&
                     ((out_data_q[22:7] & out_data_q[54:39]) == '0) &&
                     ((out_data_q[38:23] & out_data_q[54:39]) == '0)))
    else $error("light shows more than one color");

  // The reported phase is always one of the seven phases.
  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[2:0] <= PhLast))
    else $error("phase out of range");

  // Taking a request clears it.
  a_taken_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[3]) |-> (out_data_q[6:4] == '0))
    else $error("request taken but still pending");

endmodule
